// File: src/bdcp_pkg.sv
package bdcp_pkg;

  localparam int MAX_CLUSTERS   = 16;
  localparam int MAX_DIMENSIONS = 32;
  localparam int COORD_BITS     = 24;
  localparam int DIST_BITS      = 55;
  localparam int CL_W           = 4;
  localparam int DIM_W          = 5;
  localparam int NCL_W          = 5;
  localparam int CTOL_W         = 8;
  localparam int DTOL_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int ABS_W          = COORD_BITS + 1;
  localparam int SQ_W           = 2 * ABS_W;
  localparam int DIFF_W         = COORD_BITS + 4;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_COORD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CLUSTERS = 2'd0,
    REG_COORD_TOL    = 2'd1,
    REG_DIST_TOL     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCAN_MAX,
    ST_SCAN_MIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                         valid;
    logic [DIM_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] coord;
    logic [CTOL_W-1:0]            ctol;
  } tok_t;

  typedef struct packed {
    logic                         en;
    logic [DIM_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] lo;
    logic signed [COORD_BITS-1:0] hi;
  } wr_t;

endpackage

// File: src/bdcp_in_if.sv
interface bdcp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [bdcp_pkg::CL_W-1:0]             cluster_index;
  logic [bdcp_pkg::DIM_W-1:0]            dim_index;
  logic signed [bdcp_pkg::COORD_BITS-1:0] box_lower;
  logic signed [bdcp_pkg::COORD_BITS-1:0] box_upper;
  logic signed [bdcp_pkg::COORD_BITS-1:0] coordinate;
  logic                                  last_coordinate;
  logic [bdcp_pkg::MAX_CLUSTERS-1:0]     fixed_one_mask;
  logic [bdcp_pkg::MAX_CLUSTERS-1:0]     free_mask;

  modport source (output valid, operation, cluster_index, dim_index, box_lower, box_upper,
                  coordinate, last_coordinate, fixed_one_mask, free_mask, input ready);
  modport sink (input valid, operation, cluster_index, dim_index, box_lower, box_upper,
                coordinate, last_coordinate, fixed_one_mask, free_mask, output ready);
endinterface

// File: src/bdcp_out_if.sv
interface bdcp_out_if;
  logic                              valid;
  logic                              ready;
  logic [bdcp_pkg::MAX_CLUSTERS-1:0] exclude_mask;
  logic [bdcp_pkg::NCL_W-1:0]        exclusion_count;
  logic                              infeasible;
  logic [bdcp_pkg::DIST_BITS-1:0]    min_max_distance;

  modport source (output valid, exclude_mask, exclusion_count, infeasible, min_max_distance,
                  input ready);
  modport sink (input valid, exclude_mask, exclusion_count, infeasible, min_max_distance,
                output ready);
endinterface

// File: src/bdcp_cfg_if.sv
interface bdcp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bdcp_pkg::CFG_IDX_W-1:0]    index;
  logic [bdcp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/bdcp_cell.sv
module bdcp_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  bdcp_pkg::tok_t                   tok_in,
  output bdcp_pkg::tok_t                   tok_out,
  input  bdcp_pkg::wr_t                    wr,
  input  logic                             active,
  input  logic                             clear,
  output logic [bdcp_pkg::DIST_BITS-1:0]   min_acc,
  output logic [bdcp_pkg::DIST_BITS-1:0]   max_acc
);
  import bdcp_pkg::*;

  logic [2*COORD_BITS-1:0] box_mem [MAX_DIMENSIONS];
  logic [2*COORD_BITS-1:0] rd;

  logic                    s2_valid, s3_valid;
  logic [ABS_W-1:0]        s2_amin, s2_amax;
  logic [SQ_W-1:0]         s3_sqmin, s3_sqmax;

  logic signed [DIFF_W-1:0] pw, lbw, ubw, ctw, d_pu, d_pl;
  logic                     above, below, pick_up;
  logic [ABS_W-1:0]         abs_pu, abs_pl, amin, amax;
  logic [DIST_BITS:0]       sum_min, sum_max;

  function automatic logic [ABS_W-1:0] abs_of(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[ABS_W-1:0];
  endfunction

  // Box memory; read data lines up with the token handed to the neighbor
  always_ff @(posedge clk) begin
    if (wr.en) begin
      box_mem[wr.dim] <= {wr.hi, wr.lo};
    end
    rd <= box_mem[tok_in.dim];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.dim   <= tok_in.dim;
    tok_out.coord <= tok_in.coord;
    tok_out.ctol  <= tok_in.ctol;
  end

  always_comb begin
    pw      = DIFF_W'(tok_out.coord);
    lbw     = DIFF_W'($signed(rd[COORD_BITS-1:0]));
    ubw     = DIFF_W'($signed(rd[2*COORD_BITS-1:COORD_BITS]));
    ctw     = $signed({{(DIFF_W-CTOL_W){1'b0}}, tok_out.ctol});
    d_pu    = pw - ubw;
    d_pl    = pw - lbw;
    above   = (d_pu + ctw) > 0;
    below   = (d_pl - ctw) < 0;
    pick_up = (d_pl + d_pu + ctw) < 0;
    abs_pu  = abs_of(d_pu);
    abs_pl  = abs_of(d_pl);
    if (above) begin
      amin = abs_pu;
      amax = abs_pl;
    end else if (below) begin
      amin = abs_pl;
      amax = abs_pu;
    end else begin
      amin = '0;
      amax = pick_up ? abs_pu : abs_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= tok_out.valid;
      s3_valid <= s2_valid;
    end
    s2_amin  <= amin;
    s2_amax  <= amax;
    s3_sqmin <= s2_amin * s2_amin;
    s3_sqmax <= s2_amax * s2_amax;
  end

  assign sum_min = {1'b0, min_acc} + (DIST_BITS+1)'(s3_sqmin);
  assign sum_max = {1'b0, max_acc} + (DIST_BITS+1)'(s3_sqmax);

  // Saturating accumulate
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      min_acc <= '0;
      max_acc <= '0;
    end else if (s3_valid && active) begin
      min_acc <= sum_min[DIST_BITS] ? DIST_MAX : sum_min[DIST_BITS-1:0];
      max_acc <= sum_max[DIST_BITS] ? DIST_MAX : sum_max[DIST_BITS-1:0];
    end
  end

endmodule

// File: src/box_distance_cluster_pruner.sv
// Box-distance cluster pruner. A load transfer (operation 0) writes one dimension of one
// cluster's centroid box and leaves the block idle. A coordinate transfer (operation 1)
// enters a chain of sixteen cells, one per cluster; each cell holds its cluster's box memory
// and its squared min/max distance accumulators and passes the coordinate to its neighbor
// through a register. A coordinate keeps the block busy, accepting no new item, while it
// runs down the chain and through the four-stage cell pipeline (read, classify, square,
// accumulate). A last coordinate adds a scan over the cells for the smallest max distance,
// a second scan for exclusions, and a load of the result register. The result register
// holds one result until it is taken; the next item may be accepted meanwhile. Box entries
// must be written before any coordinate reads them. Configuration writes are always ready.
module box_distance_cluster_pruner (
  input logic clk,
  input logic rst,
  bdcp_in_if.sink    item,
  bdcp_out_if.source result,
  bdcp_cfg_if.sink   cfg
);
  import bdcp_pkg::*;

  localparam int LAT   = MAX_CLUSTERS + 4;
  localparam int RUN_W = $clog2(LAT + 1);

  state_t state, state_next;

  logic [NCL_W-1:0]        num_clusters;
  logic [CTOL_W-1:0]       coord_tol;
  logic [DTOL_W-1:0]       dist_tol;
  logic [NCL_W-1:0]        n_use;

  logic                    item_xfer;
  logic [RUN_W-1:0]        run_cnt;
  logic [CL_W-1:0]         scan_k;
  logic                    last_q;
  logic [MAX_CLUSTERS-1:0] fixed_q, free_q;
  logic [DIST_BITS-1:0]    minmax;
  logic [MAX_CLUSTERS-1:0] mask;
  logic [NCL_W-1:0]        count;
  logic                    infeas, stop;
  logic                    clear;

  tok_t                    tok [MAX_CLUSTERS+1];
  wr_t                     wr_bus [MAX_CLUSTERS];
  logic [DIST_BITS-1:0]    min_accs [MAX_CLUSTERS];
  logic [DIST_BITS-1:0]    max_accs [MAX_CLUSTERS];

  logic [DIST_BITS-1:0]    cur_min, cur_max;
  logic                    in_use;
  logic [DIST_BITS:0]      max_plus_tol, minmax_plus_tol;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == ST_IDLE);
  assign item_xfer  = item.valid && item.ready;

  // Clamp cluster count at the chain length
  assign n_use = (num_clusters > NCL_W'(MAX_CLUSTERS)) ? NCL_W'(MAX_CLUSTERS) : num_clusters;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NCL_W'(1);
      coord_tol    <= '0;
      dist_tol     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_NUM_CLUSTERS: num_clusters <= cfg.data[NCL_W-1:0];
        REG_COORD_TOL:    coord_tol    <= cfg.data[CTOL_W-1:0];
        REG_DIST_TOL:     dist_tol     <= cfg.data[DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Launch a coordinate token into the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= item_xfer && (item.operation == OP_COORD);
    end
    tok[0].dim   <= item.dim_index;
    tok[0].coord <= item.coordinate;
    tok[0].ctol  <= coord_tol;
  end

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    always_comb begin
      wr_bus[k].en  = item_xfer && (item.operation == OP_LOAD) &&
                      (item.cluster_index == CL_W'(k));
      wr_bus[k].dim = item.dim_index;
      wr_bus[k].lo  = item.box_lower;
      wr_bus[k].hi  = item.box_upper;
    end

    bdcp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .wr      (wr_bus[k]),
      .active  (NCL_W'(k) < n_use),
      .clear   (clear),
      .min_acc (min_accs[k]),
      .max_acc (max_accs[k])
    );
  end

  assign cur_min         = min_accs[scan_k];
  assign cur_max         = max_accs[scan_k];
  assign in_use          = {1'b0, scan_k} < n_use;
  assign max_plus_tol    = {1'b0, cur_max} + (DIST_BITS+1)'(dist_tol);
  assign minmax_plus_tol = {1'b0, minmax} + (DIST_BITS+1)'(dist_tol);

  always_comb begin
    state_next = state;
    clear      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_xfer && item.operation == OP_COORD) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_cnt == RUN_W'(LAT)) begin
          state_next = last_q ? ST_SCAN_MAX : ST_IDLE;
        end
      end
      ST_SCAN_MAX: begin
        if (scan_k == CL_W'(MAX_CLUSTERS - 1)) begin
          state_next = ST_SCAN_MIN;
        end
      end
      ST_SCAN_MIN: begin
        if (scan_k == CL_W'(MAX_CLUSTERS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free, then wipe the accumulators
        if (!result.valid) begin
          clear      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
      scan_k  <= '0;
      last_q  <= 1'b0;
      minmax  <= DIST_MAX;
      mask    <= '0;
      count   <= '0;
      infeas  <= 1'b0;
      stop    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          run_cnt <= '0;
          scan_k  <= '0;
          minmax  <= DIST_MAX;
          mask    <= '0;
          count   <= '0;
          infeas  <= 1'b0;
          stop    <= 1'b0;
          if (item_xfer) begin
            last_q  <= item.last_coordinate;
            fixed_q <= item.fixed_one_mask;
            free_q  <= item.free_mask;
          end
        end
        ST_RUN: begin
          run_cnt <= run_cnt + 1'b1;
        end
        ST_SCAN_MAX: begin
          scan_k <= scan_k + 1'b1;
          if (in_use && max_plus_tol < {1'b0, minmax}) begin
            minmax <= cur_max;
          end
        end
        ST_SCAN_MIN: begin
          scan_k <= scan_k + 1'b1;
          // Stop at the first excluded cluster that is already fixed to one
          if (in_use && !stop && {1'b0, cur_min} > minmax_plus_tol) begin
            if (fixed_q[scan_k]) begin
              infeas <= 1'b1;
              stop   <= 1'b1;
            end else if (free_q[scan_k]) begin
              mask[scan_k] <= 1'b1;
              count        <= count + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (clear) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (clear) begin
      result.exclude_mask     <= mask;
      result.exclusion_count  <= count;
      result.infeasible       <= infeas;
      result.min_max_distance <= minmax;
    end
  end

  // Checks
  a_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.exclusion_count == NCL_W'($countones(result.exclude_mask))))
    else $error("exclusion count does not match mask");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside result load");

  a_nofix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> ((mask & fixed_q) == '0))
    else $error("fixed cluster excluded");

endmodule
